/* rtl/core/mrmr_pkg.sv */
// Shared types, sizes and codes for the mRMR feature selector.
`timescale 1ns / 1ps
package mrmr_pkg;

    localparam int MAX_FEATURES = 1024;
    localparam int INFO_BITS    = 16;
    localparam int IDX_BITS     = $clog2(MAX_FEATURES);
    localparam int CNT_BITS     = IDX_BITS + 1;
    localparam int RED_BITS     = INFO_BITS + 10;
    localparam int SCORE_BITS   = RED_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(RED_BITS + 1);
    localparam int QDEPTH       = 2;
    localparam int QPTR_BITS    = $clog2(QDEPTH);
    localparam int QCNT_BITS    = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = CNT_BITS;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_MUTUAL = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CLASS  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FCOUNT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET = 2'd2;

    typedef struct packed {
        logic                 operation;
        logic [IDX_BITS-1:0]  feature_index;
        logic [INFO_BITS-1:0] info_value;
        logic                 batch_end;
    } t_in_word;

    typedef struct packed {
        logic [IDX_BITS-1:0] chosen_feature;
        logic [IDX_BITS-1:0] selection_rank;
        logic                none_found;
        logic                selection_done;
    } t_out_word;

    typedef struct packed {
        logic [IDX_BITS-1:0] class_index;
        logic [CNT_BITS-1:0] feature_count;
        logic [CNT_BITS-1:0] target_count;
    } t_cfg;

    // classified word handed from front to back
    typedef struct packed {
        logic                 op;
        logic [IDX_BITS-1:0]  fi;
        logic [INFO_BITS-1:0] val;
        logic                 last;
        logic                 elig;
    } t_cmd;

endpackage

/* rtl/core/mrmr_front.sv */
// Input side: accepts words, tags index eligibility, buffers them in a short queue.
`timescale 1ns / 1ps
module mrmr_front import mrmr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_word i_in_word,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_pop
);

    t_cmd                 r_q [QDEPTH];
    logic [QPTR_BITS-1:0] r_wp, r_rp;
    logic [QCNT_BITS-1:0] r_cnt;
    logic                 push, pop;
    t_cmd                 cmd_in;

    assign o_in_ready  = (r_cnt != QCNT_BITS'(QDEPTH));
    assign push        = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = i_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        cmd_in.op   = i_in_word.operation;
        cmd_in.fi   = i_in_word.feature_index;
        cmd_in.val  = i_in_word.info_value;
        cmd_in.last = i_in_word.batch_end;
        // index must be in use and not the class column
        cmd_in.elig = ({1'b0, i_in_word.feature_index} < i_cfg.feature_count) &&
                      (i_in_word.feature_index != i_cfg.class_index);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QPTR_BITS'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == QPTR_BITS'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/mrmr_div.sv */
// Restoring divider, one quotient bit per cycle: redundancy / selected count.
`timescale 1ns / 1ps
module mrmr_div import mrmr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [RED_BITS-1:0] i_dividend,
    input  logic [CNT_BITS-1:0] i_divisor,
    output logic                o_busy,
    output logic                o_done,
    output logic [RED_BITS-1:0] o_quot
);

    logic [RED_BITS-1:0]     r_quo;
    logic [CNT_BITS-1:0]     r_rem;
    logic [CNT_BITS-1:0]     r_dvs;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic                    r_busy, r_done;
    logic [CNT_BITS:0]       shifted;
    logic [CNT_BITS:0]       diff;
    logic                    qbit;

    always_comb begin
        shifted = {r_rem, r_quo[RED_BITS-1]};
        diff    = shifted - {1'b0, r_dvs};
        qbit    = (shifted >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[RED_BITS-2:0], qbit};
            r_rem <= qbit ? diff[CNT_BITS-1:0] : shifted[CNT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_BITS'(RED_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

/* rtl/core/mrmr_back.sv */
// Execution side: relevance and redundancy memories, scan, scoring and result register.
`timescale 1ns / 1ps
module mrmr_back import mrmr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_PICK  = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_CLOSE = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    localparam logic signed [SCORE_BITS-1:0] NO_SCORE = {1'b1, {(SCORE_BITS-1){1'b0}}};
    localparam logic [RED_BITS-1:0] RED_CAP = '1;

    function automatic logic f_is_last(input logic [CNT_BITS-1:0] tot, input t_cfg cfg);
        logic [CNT_BITS-1:0] fc;
        logic [CNT_BITS-1:0] lim;
        fc  = (cfg.feature_count > CNT_BITS'(MAX_FEATURES)) ? CNT_BITS'(MAX_FEATURES)
                                                           : cfg.feature_count;
        lim = (fc == '0) ? '0 : fc - 1'b1;
        return (tot >= lim) || (tot >= cfg.target_count);
    endfunction

    // memories: relevance, and {selected, redundancy} per feature
    logic [INFO_BITS-1:0] rel_mem [MAX_FEATURES];
    logic [RED_BITS:0]    rs_mem  [MAX_FEATURES];
    logic [INFO_BITS-1:0] rel_rd;
    logic [RED_BITS:0]    rs_rd;

    logic                 rel_we, rs_we;
    logic [IDX_BITS-1:0]  rel_wa, rel_ra, rs_wa, rs_ra;
    logic [INFO_BITS-1:0] rel_wd;
    logic [RED_BITS:0]    rs_wd;

    always_ff @(posedge i_clk) begin
        if (rel_we) begin
            rel_mem[rel_wa] <= rel_wd;
        end
        rel_rd <= rel_mem[rel_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rs_we) begin
            rs_mem[rs_wa] <= rs_wd;
        end
        rs_rd <= rs_mem[rs_ra];
    end

    logic [2:0]                   r_state, n_state;
    logic [CNT_BITS-1:0]          r_total, n_total;
    logic                         r_finished, n_finished;
    logic signed [SCORE_BITS-1:0] r_best_score, n_best_score;
    logic [IDX_BITS-1:0]          r_best_idx, n_best_idx;
    logic [CNT_BITS-1:0]          r_idx, n_idx;
    logic                         r_pvld, n_pvld;
    logic [IDX_BITS-1:0]          r_pidx, n_pidx;
    logic [INFO_BITS-1:0]         r_bestval, n_bestval;
    logic                         r_found, n_found;
    t_cmd                         r_cur, n_cur;
    logic [INFO_BITS-1:0]         r_rel, n_rel;
    t_out_word                    r_res, n_res;
    logic                         r_out_vld, n_out_vld;
    t_out_word                    r_out, n_out;

    logic                         div_start, div_busy, div_done;
    logic [RED_BITS-1:0]          div_dividend, div_quot;
    logic [RED_BITS:0]            sum;
    logic [RED_BITS-1:0]          red_new;
    logic signed [SCORE_BITS-1:0] score;
    logic [CNT_BITS-1:0]          fc_used;

    mrmr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_total),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        fc_used = (i_cfg.feature_count > CNT_BITS'(MAX_FEATURES)) ? CNT_BITS'(MAX_FEATURES)
                                                                 : i_cfg.feature_count;
        sum     = {1'b0, rs_rd[RED_BITS-1:0]} + {{(RED_BITS+1-INFO_BITS){1'b0}}, r_cur.val};
        red_new = sum[RED_BITS] ? RED_CAP : sum[RED_BITS-1:0];
        score   = $signed({{(SCORE_BITS-INFO_BITS){1'b0}}, r_rel}) -
                  $signed({1'b0, div_quot});
    end

    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        n_finished   = r_finished;
        n_best_score = r_best_score;
        n_best_idx   = r_best_idx;
        n_idx        = r_idx;
        n_pvld       = r_pvld;
        n_pidx       = r_pidx;
        n_bestval    = r_bestval;
        n_found      = r_found;
        n_cur        = r_cur;
        n_rel        = r_rel;
        n_res        = r_res;
        o_pop        = 1'b0;
        rel_we       = 1'b0;
        rel_wa       = i_cmd.fi;
        rel_wd       = i_cmd.val;
        rel_ra       = i_cmd.fi;
        rs_we        = 1'b0;
        rs_wa        = r_cur.fi;
        rs_wd        = '0;
        rs_ra        = i_cmd.fi;
        div_start    = 1'b0;
        div_dividend = red_new;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    n_cur = i_cmd;
                    if (i_cmd.op == OP_LOAD) begin
                        rel_we = 1'b1;
                        if (i_cmd.last) begin
                            n_state   = ST_SCAN;
                            n_idx     = '0;
                            n_pvld    = 1'b0;
                            n_found   = 1'b0;
                            n_bestval = '0;
                            n_best_idx = '0;
                        end
                    end else if (!r_finished && r_total != '0) begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_SCAN: begin
                // issue one read per cycle and clear the same entry's redundancy
                if (r_idx != CNT_BITS'(MAX_FEATURES)) begin
                    rel_ra = r_idx[IDX_BITS-1:0];
                    rs_we  = 1'b1;
                    rs_wa  = r_idx[IDX_BITS-1:0];
                    rs_wd  = '0;
                    n_idx  = r_idx + 1'b1;
                    n_pvld = 1'b1;
                    n_pidx = r_idx[IDX_BITS-1:0];
                end else begin
                    n_pvld = 1'b0;
                    if (!r_pvld) begin
                        n_state = ST_PICK;
                    end
                end
                if (r_pvld && ({1'b0, r_pidx} < fc_used) &&
                    (r_pidx != i_cfg.class_index) && (rel_rd > r_bestval)) begin
                    n_bestval  = rel_rd;
                    n_best_idx = r_pidx;
                    n_found    = 1'b1;
                end
            end
            ST_PICK: begin
                n_best_score = NO_SCORE;
                n_state      = ST_EMIT;
                if (!r_found) begin
                    n_total    = '0;
                    n_finished = 1'b1;
                    n_best_idx = '0;
                    n_res      = '{chosen_feature: '0, selection_rank: '0,
                                   none_found: 1'b1, selection_done: 1'b1};
                end else begin
                    rs_we      = 1'b1;
                    rs_wa      = r_best_idx;
                    rs_wd      = {1'b1, {RED_BITS{1'b0}}};
                    n_total    = CNT_BITS'(1);
                    n_finished = f_is_last(CNT_BITS'(1), i_cfg);
                    n_best_idx = '0;
                    n_res      = '{chosen_feature: r_best_idx, selection_rank: '0,
                                   none_found: 1'b0,
                                   selection_done: f_is_last(CNT_BITS'(1), i_cfg)};
                end
            end
            ST_RD: begin
                if (r_cur.elig && !rs_rd[RED_BITS]) begin
                    rs_we     = 1'b1;
                    rs_wa     = r_cur.fi;
                    rs_wd     = {1'b0, red_new};
                    div_start = 1'b1;
                    n_rel     = rel_rd;
                    n_state   = ST_DIV;
                end else begin
                    n_state = ST_CLOSE;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (score > r_best_score ||
                        (score == r_best_score && r_cur.fi < r_best_idx)) begin
                        n_best_score = score;
                        n_best_idx   = r_cur.fi;
                    end
                    n_state = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                if (!r_cur.last) begin
                    n_state = ST_IDLE;
                end else if (r_best_score == NO_SCORE) begin
                    n_finished = 1'b1;
                    n_res      = '{chosen_feature: '0, selection_rank: r_total[IDX_BITS-1:0],
                                   none_found: 1'b1, selection_done: 1'b1};
                    n_state    = ST_EMIT;
                end else begin
                    rs_we        = 1'b1;
                    rs_wa        = r_best_idx;
                    rs_wd        = {1'b1, {RED_BITS{1'b0}}};
                    n_total      = r_total + 1'b1;
                    n_finished   = f_is_last(r_total + 1'b1, i_cfg);
                    n_best_score = NO_SCORE;
                    n_best_idx   = '0;
                    n_res        = '{chosen_feature: r_best_idx,
                                     selection_rank: r_total[IDX_BITS-1:0],
                                     none_found: 1'b0,
                                     selection_done: f_is_last(r_total + 1'b1, i_cfg)};
                    n_state      = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_vld || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out     = r_out;
        n_out_vld = r_out_vld;
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        if (r_state == ST_EMIT && (!r_out_vld || i_out_ready)) begin
            n_out_vld = 1'b1;
            n_out     = r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_total      <= '0;
            r_finished   <= 1'b0;
            r_best_score <= NO_SCORE;
            r_best_idx   <= '0;
            r_idx        <= '0;
            r_pvld       <= 1'b0;
            r_found      <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_total      <= n_total;
            r_finished   <= n_finished;
            r_best_score <= n_best_score;
            r_best_idx   <= n_best_idx;
            r_idx        <= n_idx;
            r_pvld       <= n_pvld;
            r_found      <= n_found;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx    <= n_pidx;
        r_bestval <= n_bestval;
        r_cur     <= n_cur;
        r_rel     <= n_rel;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

`ifndef ASSERT_OFF
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_BITS'(MAX_FEATURES))
        else $error("selected count out of range");

    a_finish_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_finished) |-> r_state == ST_EMIT)
        else $error("finished without a pending result");
`endif

endmodule

/* rtl/core/mrmr_greedy_feature_selector.sv */
// Top level of the greedy mRMR feature selector: config registers, front, back.
//
//  channel | dir | handshake                 | word
//  in      | in  | i_in_valid / o_in_ready   | i_in_word  (t_in_word)
//  out     | out | o_out_valid / i_out_ready | o_out_word (t_out_word)
//  cfg     | in  | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// A load word without batch end writes the relevance memory in the back end.
// A round word for an eligible, unselected feature waits on the bit-serial divider.
// A load word with batch end scans all MAX_FEATURES relevance entries, one per
// cycle over one memory port, clearing redundancies.
// A two-word queue and the result register let input and output stall on their own.
// Reset is synchronous, active low; memories are not cleared by reset.
`timescale 1ns / 1ps
module mrmr_greedy_feature_selector import mrmr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_word                 i_in_word,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_word                o_out_word,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd cmd;
    logic cmd_valid, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.class_index   <= '0;
            r_cfg.feature_count <= CNT_BITS'(1024);
            r_cfg.target_count  <= CNT_BITS'(10);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CLASS:  r_cfg.class_index   <= i_cfg_data[IDX_BITS-1:0];
                CFG_FCOUNT: r_cfg.feature_count <= i_cfg_data;
                CFG_TARGET: r_cfg.target_count  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mrmr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_pop       (pop)
    );

    mrmr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the greedy mRMR feature selector.
`timescale 1ns / 1ps
module tb;
    import mrmr_pkg::*;

    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int SETTLE       = 1200;
    localparam int ITEM_BUDGET  = 2300;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    t_in_word                 i_in_word;
    logic                     o_out_valid;
    logic                     i_out_ready;
    t_out_word                o_out_word;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    mrmr_greedy_feature_selector dut (.*);

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // predictor state
    logic [INFO_BITS-1:0] rel_mem [MAX_FEATURES];
    logic [RED_BITS-1:0]  red_mem [MAX_FEATURES];
    bit                   picked  [MAX_FEATURES];
    int                   n_picked;
    longint               top_score;
    int                   top_idx;
    bit                   sel_over;
    int                   cls_reg, fc_reg, tgt_reg;

    bit                   loaded [MAX_FEATURES];  // relevance written by stimulus
    t_in_word             pend_q[$];
    t_out_word            picks_q[$];
    int                   n_err, n_acc, n_rand, cycles;
    int                   hold_left;
    bit                   hold_done;

    function automatic longint no_score();
        return -(longint'(1) << RED_BITS);
    endfunction

    function automatic int fc_used();
        return (fc_reg > MAX_FEATURES) ? MAX_FEATURES : fc_reg;
    endfunction

    function automatic bit is_final();
        int lim;
        lim = (fc_used() > 0) ? fc_used() - 1 : 0;
        return (n_picked >= lim) || (n_picked >= tgt_reg);
    endfunction

    function automatic void add_pick(int idx, int rank, bit none, bit done);
        t_out_word o;
        o.chosen_feature = idx[IDX_BITS-1:0];
        o.selection_rank = rank[IDX_BITS-1:0];
        o.none_found     = none;
        o.selection_done = done;
        picks_q = {picks_q, o};
    endfunction

    function automatic void mrmr_predict(t_in_word w);
        int fi, best, fc;
        longint bestval, r, sc;
        fi = w.feature_index;
        fc = fc_used();
        if (w.operation == OP_LOAD) begin
            rel_mem[fi] = w.info_value;
            if (!w.batch_end) return;
            for (int i = 0; i < MAX_FEATURES; i++) begin
                red_mem[i] = '0;
                picked[i]  = 1'b0;
            end
            top_score = no_score();
            top_idx   = 0;
            best      = -1;
            bestval   = 0;
            for (int i = 0; i < fc; i++) begin
                if (i != cls_reg && rel_mem[i] > bestval) begin
                    bestval = rel_mem[i];
                    best    = i;
                end
            end
            if (best < 0) begin
                n_picked = 0;
                sel_over = 1'b1;
                add_pick(0, 0, 1'b1, 1'b1);
                return;
            end
            picked[best] = 1'b1;
            n_picked     = 1;
            sel_over     = is_final();
            add_pick(best, 0, 1'b0, sel_over);
            return;
        end
        if (sel_over || n_picked == 0) return;
        if (fi < fc && fi != cls_reg && !picked[fi]) begin
            r = longint'(red_mem[fi]) + longint'(w.info_value);
            if (r > (longint'(1) << RED_BITS) - 1) r = (longint'(1) << RED_BITS) - 1;
            red_mem[fi] = r[RED_BITS-1:0];
            sc = longint'(rel_mem[fi]) - r / n_picked;
            if (sc > top_score || (sc == top_score && fi < top_idx)) begin
                top_score = sc;
                top_idx   = fi;
            end
        end
        if (!w.batch_end) return;
        if (top_score == no_score()) begin
            sel_over = 1'b1;
            add_pick(0, n_picked, 1'b1, 1'b1);
            return;
        end
        picked[top_idx] = 1'b1;
        add_pick(top_idx, n_picked, 1'b0, 1'b0);
        n_picked  = n_picked + 1;
        top_score = no_score();
        top_idx   = 0;
        sel_over  = is_final();
        picks_q[$].selection_done = sel_over;
    endfunction

    // idle rates: sender 9 / receiver 72, then swapped, then none
    function automatic bit send_idle();
        if (n_acc < 750) return $urandom_range(0, 99) < 9;
        if (n_acc < 1500) return $urandom_range(0, 99) < 72;
        return 1'b0;
    endfunction

    function automatic bit recv_idle();
        if (n_acc < 750) return $urandom_range(0, 99) < 72;
        if (n_acc < 1500) return $urandom_range(0, 99) < 9;
        return 1'b0;
    endfunction

    // input driver
    always @(posedge i_clk) begin
        bit took;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_word  <= '0;
        end else begin
            took = i_in_valid && o_in_ready;
            if (took) begin
                mrmr_predict(pend_q.pop_front());
                n_acc++;
            end
            if (!i_in_valid || took) begin
                if (pend_q.size() > 0 && !send_idle()) begin
                    i_in_valid <= 1'b1;
                    i_in_word  <= pend_q[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, once, to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_acc >= 2100) begin
            hold_left <= 3000;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        t_out_word e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (picks_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected result word %h", o_out_word);
                end else begin
                    e = picks_q.pop_front();
                    if (o_out_word.chosen_feature !== e.chosen_feature ||
                        o_out_word.selection_rank !== e.selection_rank ||
                        o_out_word.none_found !== e.none_found ||
                        o_out_word.selection_done !== e.selection_done) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("mismatch: exp feat %0d rank %0d none %b done %b, got feat %0d rank %0d none %b done %b",
                                     e.chosen_feature, e.selection_rank, e.none_found,
                                     e.selection_done, o_out_word.chosen_feature,
                                     o_out_word.selection_rank, o_out_word.none_found,
                                     o_out_word.selection_done);
                    end
                end
            end
            i_out_ready <= (hold_left == 0) && !recv_idle();
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int rand_info();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 16'hFFFF;
            2: return $urandom_range(0, 31);
            default: return $urandom_range(0, 16'hFFFF);
        endcase
    endfunction

    function automatic void put(bit op, int fi, int v, bit last);
        t_in_word w;
        w.operation     = op;
        w.feature_index = fi[IDX_BITS-1:0];
        w.info_value    = v[INFO_BITS-1:0];
        w.batch_end     = last;
        if (op == OP_LOAD) loaded[fi[IDX_BITS-1:0]] = 1'b1;
        pend_q = {pend_q, w};
        n_rand++;
    endfunction

    task automatic drain();
        wait (pend_q.size() == 0 && !i_in_valid && picks_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, int v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v[CFG_DATA_BITS-1:0];
        case (idx)
            CFG_CLASS:  cls_reg = v & 10'h3FF;
            CFG_FCOUNT: fc_reg  = v & 11'h7FF;
            CFG_TARGET: tgt_reg = v & 11'h7FF;
            default: ;
        endcase
    endtask

    task automatic set_cfg(int cls, int fc, int tgt);
        drain();
        cfg_write(CFG_CLASS, cls);
        cfg_write(CFG_FCOUNT, fc);
        cfg_write(CFG_TARGET, tgt);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // every index the scan can pick gets a relevance first
    task automatic fill_rel();
        int ufc;
        ufc = fc_used();
        for (int i = 0; i < ufc; i++)
            if (!loaded[i]) put(OP_LOAD, i, rand_info(), 1'b0);
    endtask

    task automatic rand_phase(int cls, int fc, int tgt, int rounds);
        int ufc, n, fi;
        set_cfg(cls, fc, tgt);
        ufc = fc_used();
        fill_rel();
        repeat ($urandom_range(0, 4)) put(OP_LOAD, $urandom_range(0, 1023), rand_info(), 1'b0);
        put(OP_LOAD, $urandom_range(0, (ufc > 0) ? ufc - 1 : 0), rand_info(), 1'b1);
        for (int r = 0; r < rounds; r++) begin
            n = $urandom_range(1, 10);
            for (int j = 0; j < n; j++) begin
                if ($urandom_range(0, 9) == 0) fi = $urandom_range(0, 1023);
                else fi = $urandom_range(0, (ufc > 0) ? ufc - 1 : 0);
                if ($urandom_range(0, 24) == 0)
                    put(OP_LOAD, fi, rand_info(), $urandom_range(0, 5) == 0);
                else
                    put(OP_MUTUAL, fi, rand_info(),
                        (j == n - 1) || ($urandom_range(0, 30) == 0));
            end
        end
    endtask

    initial begin
        int fc, tgt, cls;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        n_err = 0; n_acc = 0; n_rand = 0; cycles = 0;
        cls_reg = 0; fc_reg = 1024; tgt_reg = 10;
        n_picked = 0; top_score = no_score(); top_idx = 0; sel_over = 1'b0;
        for (int i = 0; i < MAX_FEATURES; i++) begin
            rel_mem[i] = '0; red_mem[i] = '0; picked[i] = 1'b0; loaded[i] = 1'b0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // round words before any load end are dropped
        put(OP_MUTUAL, 1, 16'h1234, 1'b0);
        put(OP_MUTUAL, 2, 16'h0001, 1'b1);

        // directed: no positive relevance, then class / selected / out of range,
        // tie on score, repeated word
        set_cfg(3, 6, 3);
        for (int i = 0; i < 6; i++) put(OP_LOAD, i, 0, i == 5);
        put(OP_LOAD, 1, 500, 1'b0);
        put(OP_LOAD, 2, 500, 1'b0);
        put(OP_LOAD, 3, 16'hFFFF, 1'b0);
        put(OP_LOAD, 5, 16'hFFFF, 1'b0);
        put(OP_LOAD, 0, 100, 1'b1);
        put(OP_MUTUAL, 5, 16'hFFFF, 1'b0);
        put(OP_MUTUAL, 3, 16'hFFFF, 1'b0);
        put(OP_MUTUAL, 1023, 7, 1'b0);
        put(OP_MUTUAL, 1, 16'h0010, 1'b0);
        put(OP_MUTUAL, 2, 16'h0010, 1'b0);
        put(OP_MUTUAL, 2, 0, 1'b0);
        put(OP_MUTUAL, 0, 16'hFFFF, 1'b1);
        put(OP_MUTUAL, 2, 16'h0100, 1'b1);
        put(OP_MUTUAL, 4, 1, 1'b1);

        // round where nothing is eligible
        set_cfg(0, 3, 5);
        put(OP_LOAD, 1, 9, 1'b0);
        put(OP_LOAD, 2, 3, 1'b1);
        put(OP_MUTUAL, 0, 5, 1'b0);
        put(OP_MUTUAL, 1, 5, 1'b1);

        // redundancy saturation
        set_cfg(0, 4, 3);
        put(OP_LOAD, 1, 16'hFFFF, 1'b0);
        put(OP_LOAD, 2, 16'hFFFE, 1'b0);
        put(OP_LOAD, 3, 2, 1'b1);
        for (int i = 0; i < 1030; i++) put(OP_MUTUAL, 2, 16'hFFFF, 1'b0);
        put(OP_MUTUAL, 3, 1, 1'b1);

        // count and target extremes
        rand_phase(5, 1024, 12, 13);
        rand_phase(1023, 2047, 1024, 6);
        rand_phase(0, 0, 5, 2);
        rand_phase(0, 1, 5, 2);
        rand_phase(1, 2, 1024, 3);
        rand_phase(2, 8, 0, 2);
        rand_phase(0, 8, 1, 2);

        while (n_rand < ITEM_BUDGET) begin
            case ($urandom_range(0, 3))
                0: fc = 2;
                1: fc = $urandom_range(3, 12);
                default: fc = $urandom_range(2, 64);
            endcase
            cls = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, fc - 1);
            case ($urandom_range(0, 3))
                0: tgt = 1024;
                1: tgt = 1;
                default: tgt = $urandom_range(1, fc);
            endcase
            rand_phase(cls, fc, tgt, ((tgt < fc) ? tgt : fc) + $urandom_range(0, 2));
        end

        wait (pend_q.size() == 0 && !i_in_valid && picks_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        if (n_err == 0 && picks_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
